// ----- hdl/hbs_pkg.sv -----
// package for the heightmap bilinear sampler: sizes, codes and state encoding
// no dependencies
package hbs_pkg;
	localparam int GridPoints = 81;
	localparam int AddrW = $clog2(GridPoints * GridPoints);
	localparam int IdxW = $clog2(GridPoints);
	localparam int PosW = 26;
	localparam logic [PosW-1:0] PosMax = PosW'((GridPoints - 1) * 256);
	localparam logic [1:0] ModeWrite = 2'd0;
	localparam logic [1:0] ModeHeight = 2'd1;
	localparam logic [1:0] ModeNormal = 2'd2;
	localparam logic [1:0] ModeUnused = 2'd3;
	localparam logic [0:0] CfgOrgX = 1'b0;
	localparam logic [0:0] CfgOrgZ = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETUP, ST_READ, ST_LERP, ST_SQRT, ST_DIV, ST_DONE
	} hbs_state_t;

	typedef struct packed {
		logic start;
		logic [47:0] num;
		logic [31:0] den;
	} hbs_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [47:0] quot;
	} hbs_div_rsp_t;
endpackage

// ----- hdl/hbs_grid_ram.sv -----
// height grid storage: one write port, one registered read port
// depends on hbs_pkg for the address width
module hbs_grid_ram (
	input  logic clk,
	input  logic we,
	input  logic [hbs_pkg::AddrW-1:0] waddr,
	input  logic [15:0] wdata,
	input  logic [hbs_pkg::AddrW-1:0] raddr,
	output logic [15:0] rdata
);
	import hbs_pkg::*;
	logic [15:0] mem [GridPoints*GridPoints];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/hbs_divider.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on hbs_pkg for the request and response structs
module hbs_divider (
	input  logic clk,
	input  logic arst_n,
	input  hbs_pkg::hbs_div_req_t req,
	output hbs_pkg::hbs_div_rsp_t rsp
);
	import hbs_pkg::*;
	logic [31:0] rem_q, den_q;
	logic [47:0] quo_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[47]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

// ----- hdl/heightmap_bilinear_sampler_unit.sv -----
// top level of the heightmap bilinear sampler: sequencer, lerp and sqrt datapath
// depends on hbs_pkg, hbs_grid_ram and hbs_divider
// A write passes through a setup state that writes the grid entry if its column
// and row lie in the grid, a done state that loads the result register and the
// idle state that takes the next request. A height query reads four grid entries
// one per cycle through the single memory port, interpolates in three steps and
// then loads the result register. A normal query runs four height samples in
// turn, a bit-pair integer square root of 25 steps plus a load step and three
// 48-step divisions on the one shared divider, each with start and capture.
// Requests are taken only while idle, and a stalled result holds the sequencer
// in its last state. Grid content after reset is undefined until written.
module heightmap_bilinear_sampler_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [22:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] mode,
	input  logic signed [23:0] x_pos,
	input  logic signed [23:0] z_pos,
	input  logic [6:0] grid_col,
	input  logic [6:0] grid_row,
	input  logic signed [15:0] height_in,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] result_kind,
	output logic signed [15:0] height_out,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z
);
	import hbs_pkg::*;

	hbs_state_t state_q, state_d;
	logic [22:0] org_x_q, org_z_q;
	logic [1:0] mode_q;
	logic signed [23:0] x_q, z_q;
	logic [6:0] col_q, row_q;
	logic signed [15:0] hin_q;
	logic [1:0] samp_q;   // which of four samples in a normal query
	logic [1:0] rd_q;     // grid read counter
	logic [2:0] lstep_q;  // lerp step / read wait
	logic [IdxW-1:0] ix_q, iz_q, ix1_q, iz1_q;
	logic [7:0] tx_q, tz_q;
	logic signed [15:0] h_q [4];
	logic signed [15:0] hx0_q, hx1_q, hres_q;
	logic signed [16:0] hl_q, hd_q;
	logic signed [16:0] a_q, c_q;
	logic [49:0] sq_v_q, sq_r_q, sq_bit_q;
	logic [4:0] sq_cnt_q;
	logic [1:0] dv_q;
	logic [31:0] s_root;
	logic [14:0] nres_q [3];
	logic oval_q;
	logic [1:0] okind_q;
	logic signed [15:0] oh_q, onx_q, ony_q, onz_q;

	wire acc_in = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= 23'd10240;
			org_z_q <= 23'd10240;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgOrgX: org_x_q <= cfg_data;
				CfgOrgZ: org_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample position for the current pass
	logic signed [PosW-1:0] px, pz, fx, fz;
	always_comb begin
		px = PosW'(x_q) + PosW'($signed({1'b0, org_x_q}));
		pz = PosW'(z_q) + PosW'($signed({1'b0, org_z_q}));
		if (mode_q == ModeNormal) begin
			case (samp_q)
				2'd0: px = px - PosW'(128);
				2'd1: px = px + PosW'(128);
				2'd2: pz = pz - PosW'(128);
				default: pz = pz + PosW'(128);
			endcase
		end
		fx = px[PosW-1] ? '0 : (px > $signed(PosMax) ? $signed(PosMax) : px);
		fz = pz[PosW-1] ? '0 : (pz > $signed(PosMax) ? $signed(PosMax) : pz);
	end

	// grid memory
	logic [AddrW-1:0] raddr, waddr;
	logic [15:0] rdata;
	logic we;
	logic [IdxW-1:0] rc, rr;
	always_comb begin
		case (rd_q)
			2'd0: begin rc = ix_q; rr = iz_q; end
			2'd1: begin rc = ix1_q; rr = iz_q; end
			2'd2: begin rc = ix_q; rr = iz1_q; end
			default: begin rc = ix1_q; rr = iz1_q; end
		endcase
	end
	assign raddr = AddrW'(rr * AddrW'(GridPoints)) + AddrW'(rc);
	assign waddr = AddrW'(row_q * AddrW'(GridPoints)) + AddrW'(col_q);
	assign we = state_q == ST_SETUP && mode_q == ModeWrite
		&& col_q < 7'(GridPoints) && row_q < 7'(GridPoints);

	hbs_grid_ram u_ram (.clk, .we, .waddr, .wdata(hin_q), .raddr, .rdata);

	// shared lerp: a + floor((b-a)*t/256)
	logic signed [15:0] la, lb;
	logic [7:0] lt;
	logic signed [25:0] lprod;
	logic signed [15:0] lres;
	always_comb begin
		case (lstep_q)
			3'd0: begin la = h_q[0]; lb = h_q[1]; lt = tx_q; end
			3'd1: begin la = h_q[2]; lb = h_q[3]; lt = tx_q; end
			default: begin la = hx0_q; lb = hx1_q; lt = tz_q; end
		endcase
		lprod = (26'(lb) - 26'(la)) * $signed({18'd0, lt});
		lres = 16'(26'(la) + (lprod >>> 8));
	end

	// root stays in place once the bit-pair loop has finished
	assign s_root = sq_r_q[31:0];

	// divider
	hbs_div_req_t dreq;
	hbs_div_rsp_t drsp;
	hbs_divider u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));
	logic [16:0] dmag;
	always_comb begin
		case (dv_q)
			2'd0: dmag = a_q[16] ? 17'(-a_q) : 17'(a_q);
			2'd1: dmag = 17'd256;
			default: dmag = c_q[16] ? 17'(-c_q) : 17'(c_q);
		endcase
		dreq.start = state_q == ST_DIV && !drsp.busy && !drsp.done;
		dreq.num = 48'({dmag, 23'd0}) + 48'(s_root);
		dreq.den = {s_root[30:0], 1'b0};
	end
	wire [47:0] qsat = drsp.quot > 48'd16384 ? 48'd16384 : drsp.quot;

	wire [49:0] sq_sum = sq_r_q + sq_bit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc_in && mode != ModeUnused) state_d = ST_SETUP;
			ST_SETUP: state_d = mode_q == ModeWrite ? ST_DONE : ST_READ;
			ST_READ: if (lstep_q == 3'd4) state_d = ST_LERP;
			ST_LERP: if (lstep_q == 3'd2) begin
				if (mode_q == ModeHeight) state_d = ST_DONE;
				else if (samp_q == 2'd3) state_d = ST_SQRT;
				else state_d = ST_SETUP;
			end
			ST_SQRT: if (sq_cnt_q == 5'd0) state_d = ST_DIV;
			ST_DIV: if (drsp.done && dv_q == 2'd2) state_d = ST_DONE;
			ST_DONE: if (!oval_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oval_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!oval_q || !out_stall)) oval_q <= 1'b1;
			else if (oval_q && !out_stall) oval_q <= 1'b0;
		end
	end

	logic [49:0] l2;
	assign l2 = {(34'(a_q * a_q) + 34'(c_q * c_q) + 34'd65536), 16'd0};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (acc_in) begin
				mode_q <= mode; x_q <= x_pos; z_q <= z_pos;
				col_q <= grid_col; row_q <= grid_row; hin_q <= height_in;
				samp_q <= '0;
			end
			ST_SETUP: begin
				ix_q <= IdxW'(fx[PosW-1:8]);
				iz_q <= IdxW'(fz[PosW-1:8]);
				ix1_q <= fx[PosW-1:8] >= (GridPoints - 1) ? IdxW'(GridPoints - 1)
					: IdxW'(fx[PosW-1:8] + 1);
				iz1_q <= fz[PosW-1:8] >= (GridPoints - 1) ? IdxW'(GridPoints - 1)
					: IdxW'(fz[PosW-1:8] + 1);
				tx_q <= fx[7:0]; tz_q <= fz[7:0];
				rd_q <= '0; lstep_q <= '0;
			end
			ST_READ: begin
				// read data arrives in the cycle after its address is presented
				if (lstep_q != 3'd0) h_q[lstep_q[1:0] - 2'd1] <= rdata;
				if (rd_q != 2'd3) rd_q <= rd_q + 2'd1;
				lstep_q <= lstep_q == 3'd4 ? 3'd0 : lstep_q + 3'd1;
			end
			ST_LERP: begin
				lstep_q <= lstep_q + 3'd1;
				if (lstep_q == 3'd0) hx0_q <= lres;
				if (lstep_q == 3'd1) hx1_q <= lres;
				if (lstep_q == 3'd2) begin
					hres_q <= lres;
					samp_q <= samp_q + 2'd1;
					case (samp_q)
						2'd0: hl_q <= 17'(lres);
						2'd1: a_q <= hl_q - 17'(lres);
						2'd2: hd_q <= 17'(lres);
						default: c_q <= hd_q - 17'(lres);
					endcase
					sq_cnt_q <= 5'd25;
					sq_r_q <= '0;
					sq_bit_q <= 50'd1 << 48;
				end
			end
			ST_SQRT: begin
				if (sq_cnt_q == 5'd25) sq_v_q <= l2;
				else begin
					if (sq_v_q >= sq_sum) begin
						sq_v_q <= sq_v_q - sq_sum;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
					end else sq_r_q <= sq_r_q >> 1;
					sq_bit_q <= sq_bit_q >> 2;
				end
				sq_cnt_q <= sq_cnt_q - 5'd1;
				dv_q <= '0;
			end
			ST_DIV: begin
				if (drsp.done) begin
					nres_q[dv_q] <= 15'(qsat);
					dv_q <= dv_q + 2'd1;
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && (!oval_q || !out_stall)) begin
			okind_q <= mode_q;
			oh_q <= mode_q == ModeHeight ? hres_q : '0;
			onx_q <= mode_q == ModeNormal
				? (a_q[16] ? -$signed({1'b0, nres_q[0]}) : $signed({1'b0, nres_q[0]})) : '0;
			ony_q <= mode_q == ModeNormal ? $signed({1'b0, nres_q[1]}) : '0;
			onz_q <= mode_q == ModeNormal
				? (c_q[16] ? -$signed({1'b0, nres_q[2]}) : $signed({1'b0, nres_q[2]})) : '0;
		end
	end

	assign out_valid = oval_q;
	assign result_kind = okind_q;
	assign height_out = oh_q;
	assign normal_x = onx_q;
	assign normal_y = ony_q;
	assign normal_z = onz_q;
endmodule

// ----- hdl/hbs_checker.sv -----
// port-level checks for the heightmap bilinear sampler
// depends on hbs_pkg; bound to heightmap_bilinear_sampler_unit
module hbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] result_kind
);
	import hbs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind))
		else $error("result dropped while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_kind != ModeUnused)
		else $error("result of unused mode");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result before work done");
endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .result_kind
);

// ----- dv/heightmap_bilinear_sampler_unit_test.sv -----
// testbench for heightmap_bilinear_sampler_unit: queue-fed driver, clocked monitor, own predictor
// depends on hbs_pkg and the sampler rtl
module heightmap_bilinear_sampler_unit_test;
	import hbs_pkg::*;

	localparam int Pts = 81;
	localparam int Cells = Pts * Pts;
	localparam int CycleLimit = 2000000;

	typedef struct {
		logic [1:0] mode;
		logic signed [23:0] x;
		logic signed [23:0] z;
		logic [6:0] col;
		logic [6:0] row;
		logic signed [15:0] h;
	} request_t;

	typedef struct {
		logic [1:0] kind;
		logic signed [15:0] h;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CfgOrgX;
	logic [22:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = ModeWrite;
	logic signed [23:0] x_pos = '0;
	logic signed [23:0] z_pos = '0;
	logic [6:0] grid_col = '0;
	logic [6:0] grid_row = '0;
	logic signed [15:0] height_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] result_kind;
	logic signed [15:0] height_out, normal_x, normal_y, normal_z;

	heightmap_bilinear_sampler_unit dut (.*);

	always #5 clk = ~clk;

	request_t pending_reqs[$];
	sample_t expected_samples[$];
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int mismatches = 0;
	int cycles = 0;

	// predictor state
	logic signed [15:0] model_grid [Cells];
	longint model_org_x = 10240;
	longint model_org_z = 10240;

	// generator view: which entries have been written, and the origin in force
	bit written [Cells];
	longint gen_org_x = 10240;
	longint gen_org_z = 10240;

	function automatic longint clamp_pos(longint p);
		if (p < 0) return 0;
		if (p > (Pts - 1) * 256) return (Pts - 1) * 256;
		return p;
	endfunction

	function automatic longint floor_div256(longint v);
		if (v >= 0) return v >>> 8;
		return -((-v + 255) >>> 8);
	endfunction

	function automatic longint interp_height(longint px, longint pz);
		longint fx, fz, ix, iz, tx, tz, ix1, iz1, h00, h10, h01, h11, hx0, hx1;
		fx = clamp_pos(px + model_org_x);
		fz = clamp_pos(pz + model_org_z);
		ix = fx >>> 8; iz = fz >>> 8;
		tx = fx & 255; tz = fz & 255;
		ix1 = (ix + 1 < Pts) ? ix + 1 : Pts - 1;
		iz1 = (iz + 1 < Pts) ? iz + 1 : Pts - 1;
		h00 = model_grid[iz * Pts + ix];
		h10 = model_grid[iz * Pts + ix1];
		h01 = model_grid[iz1 * Pts + ix];
		h11 = model_grid[iz1 * Pts + ix1];
		hx0 = h00 + floor_div256((h10 - h00) * tx);
		hx1 = h01 + floor_div256((h11 - h01) * tx);
		return hx0 + floor_div256((hx1 - hx0) * tz);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] unit_comp(longint comp, longint unsigned s);
		longint unsigned mag, q;
		mag = (comp < 0) ? -comp : comp;
		q = ((mag << 23) + s) / (2 * s);
		if (q > 16384) q = 16384;
		return (comp < 0) ? -16'(q) : 16'(q);
	endfunction

	function automatic sample_t predict_sample(request_t r);
		sample_t e;
		longint a, c;
		longint unsigned s;
		e = '{kind: r.mode, h: 0, nx: 0, ny: 0, nz: 0};
		if (r.mode == ModeWrite) begin
			if (r.col < Pts && r.row < Pts) model_grid[r.row * Pts + r.col] = r.h;
		end else if (r.mode == ModeHeight) begin
			e.h = 16'(interp_height(r.x, r.z));
		end else if (r.mode == ModeNormal) begin
			a = interp_height(r.x - 128, r.z) - interp_height(r.x + 128, r.z);
			c = interp_height(r.x, r.z - 128) - interp_height(r.x, r.z + 128);
			s = int_sqrt(longint'(a * a + c * c + 65536) << 16);
			e.nx = unit_comp(a, s);
			e.ny = unit_comp(256, s);
			e.nz = unit_comp(c, s);
		end
		return e;
	endfunction

	// generator helpers: any entry a query will read is written first
	task automatic push_write(int c, int r, logic signed [15:0] h);
		request_t nr;
		nr = '{ModeWrite, 24'sd0, 24'sd0, 7'(c), 7'(r), h};
		pending_reqs.insert(pending_reqs.size(), nr);
		if (c < Pts && r < Pts) written[r * Pts + c] = 1'b1;
	endtask

	task automatic need_cells(longint px, longint pz);
		longint fx, fz, ix, iz, ix1, iz1;
		fx = clamp_pos(px + gen_org_x);
		fz = clamp_pos(pz + gen_org_z);
		ix = fx >>> 8; iz = fz >>> 8;
		ix1 = (ix + 1 < Pts) ? ix + 1 : Pts - 1;
		iz1 = (iz + 1 < Pts) ? iz + 1 : Pts - 1;
		if (!written[iz * Pts + ix]) push_write(int'(ix), int'(iz), 16'($urandom));
		if (!written[iz * Pts + ix1]) push_write(int'(ix1), int'(iz), 16'($urandom));
		if (!written[iz1 * Pts + ix]) push_write(int'(ix), int'(iz1), 16'($urandom));
		if (!written[iz1 * Pts + ix1]) push_write(int'(ix1), int'(iz1), 16'($urandom));
	endtask

	task automatic push_query(logic [1:0] m, logic signed [23:0] x, logic signed [23:0] z);
		request_t nr;
		if (m == ModeHeight) need_cells(x, z);
		if (m == ModeNormal) begin
			need_cells(x - 128, z);
			need_cells(x + 128, z);
			need_cells(x, z - 128);
			need_cells(x, z + 128);
		end
		nr = '{m, x, z, 7'($urandom), 7'($urandom), 16'($urandom)};
		pending_reqs.insert(pending_reqs.size(), nr);
	endtask

	function automatic logic signed [23:0] pick_pos(longint org);
		longint p;
		if ($urandom_range(3) == 0) return 24'($urandom);
		p = longint'($urandom_range(80 * 256 + 600)) - 300 - org;
		if (p < -8388608) p = -8388608;
		if (p > 8388607) p = 8388607;
		return 24'(p);
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		// a trailing unused-mode request leaves no result to wait for
		repeat (250) @(posedge clk);
	endtask

	task automatic set_origin(logic [22:0] ox, logic [22:0] oz);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= CfgOrgX; cfg_data <= ox;
		@(negedge clk);
		cfg_index <= CfgOrgZ; cfg_data <= oz;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_org_x = ox; model_org_z = oz;
		gen_org_x = ox; gen_org_z = oz;
	endtask

	// driver: takes the next request once the current one is accepted
	bit req_taken;
	always @(posedge clk) begin
		req_taken = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			sample_t e;
			request_t r;
			r = '{mode, x_pos, z_pos, grid_col, grid_row, height_in};
			e = predict_sample(r);
			if (r.mode != ModeUnused) expected_samples.insert(expected_samples.size(), e);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
		if (!in_valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				request_t r;
				r = pending_reqs.pop_front();
				mode <= r.mode; x_pos <= r.x; z_pos <= r.z;
				grid_col <= r.col; grid_row <= r.row; height_in <= r.h;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind %0d", result_kind);
			end else begin
				sample_t e;
				e = expected_samples.pop_front();
				if (e.kind !== result_kind || e.h !== height_out || e.nx !== normal_x ||
						e.ny !== normal_y || e.nz !== normal_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp k%0d h%0d n(%0d %0d %0d) got k%0d h%0d n(%0d %0d %0d)",
							e.kind, e.h, e.nx, e.ny, e.nz, result_kind, height_out,
							normal_x, normal_y, normal_z);
				end
			end
		end
	end

	initial begin
		logic [22:0] org_x [6];
		logic [22:0] org_z [6];
		logic [1:0] m;
		int pick;
		org_x = '{23'd10240, 23'd0, 23'h7fffff, 23'd10240, 23'd0, 23'd5000};
		org_z = '{23'd10240, 23'h7fffff, 23'd0, 23'd20480, 23'd10240, 23'd15000};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: grid corners, extreme heights and positions, bad writes, unused mode
		snd_idle_pct = 27; rcv_idle_pct = 81;
		push_write(0, 0, 16'sh7fff);
		push_write(1, 0, -16'sh8000);
		push_write(0, 1, -16'sh8000);
		push_write(1, 1, 16'sh7fff);
		push_write(80, 80, -16'sh8000);
		push_write(127, 127, 16'sh1234);
		push_write(81, 3, 16'sh0100);
		push_query(ModeHeight, -24'sh800000, -24'sh800000);
		push_query(ModeHeight, 24'sh7fffff, 24'sh7fffff);
		push_query(ModeHeight, -24'sd10240 + 24'sd128, -24'sd10240 + 24'sd200);
		push_query(ModeNormal, -24'sd10240 + 24'sd128, -24'sd10240 + 24'sd128);
		push_query(ModeNormal, -24'sh800000, 24'sh7fffff);
		push_query(ModeNormal, 24'sd10240, 24'sd10240);
		push_query(ModeNormal, 24'sd0, 24'sd0);
		push_query(ModeUnused, 24'sh7fffff, -24'sh800000);
		push_query(ModeHeight, 24'sd10239, -24'sd10240);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			set_origin(org_x[ph], org_z[ph]);
			if (ph < 2) begin snd_idle_pct = 27; rcv_idle_pct = 81; end
			else if (ph < 4) begin snd_idle_pct = 81; rcv_idle_pct = 27; end
			else begin snd_idle_pct = 0; rcv_idle_pct = 0; end
			for (int i = 0; i < 85; i++) begin
				pick = $urandom_range(99);
				if (pick < 25) push_write($urandom_range(127), $urandom_range(127), 16'($urandom));
				else if (pick < 30) push_query(ModeUnused, 24'($urandom), 24'($urandom));
				else begin
					m = (pick < 65) ? ModeHeight : ModeNormal;
					push_query(m, pick_pos(gen_org_x), pick_pos(gen_org_z));
				end
			end
		end

		wait_drained();
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
